@@ sv/assert_macros.svh @@
// Assertion macros shared by the sprite frame sequencer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sfs_pkg.sv @@
// Shared types, widths and codes for the sprite frame sequencer.
// No dependencies; used by every other file of the block but assert_macros.svh.
`timescale 1ns / 1ps

package sfs_pkg;

	// Field and datapath widths
	localparam int OP_W        = 3;
	localparam int DUR_W       = 16;
	localparam int TIDX_W      = 4;
	localparam int FIDX_W      = 4;
	localparam int ADV_W       = 7;
	localparam int FC_W        = 5;
	localparam int SPEED_W     = 16;
	localparam int ACC_W       = 40;
	localparam int FRAC_W      = 8;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;

	// Most frame advances done by one tick
	localparam int MAX_ADVANCE = 64;
	localparam logic [ADV_W-1:0] ADV_CAP = ADV_W'(MAX_ADVANCE);

	// Item opcodes
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_START  = 3'd1;
	localparam logic [OP_W-1:0] OP_RESUME = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
	localparam logic [OP_W-1:0] OP_PAUSE  = 3'd4;
	localparam logic [OP_W-1:0] OP_WRDUR  = 3'd5;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_FRAME_COUNT    = 2'd0;
	localparam logic [1:0] REG_LOOP_ENABLE    = 2'd1;
	localparam logic [1:0] REG_DEFAULT_PERIOD = 2'd2;
	localparam logic [1:0] REG_PLAYBACK_SPEED = 2'd3;

	// Register reset values
	localparam logic [FC_W-1:0]    FRAME_COUNT_RST = 5'd1;
	localparam logic [SPEED_W-1:0] SPEED_RST       = 16'd256;

	// Shared add/subtract unit request and answer
	typedef struct packed {
		logic             sub;
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ACC_W-1:0] value;
		logic             carry;   // carry out on add, borrow on subtract
	} alu_rsp_t;

endpackage

@@ sv/sfs_if.sv @@
// Valid/ready channel interfaces: command items in, status items out.
// Depends on sfs_pkg for field widths.
`timescale 1ns / 1ps

interface sfs_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [sfs_pkg::OP_W-1:0]    op;
	logic [sfs_pkg::DUR_W-1:0]   time_delta;
	logic [sfs_pkg::TIDX_W-1:0]  table_index;
	logic [sfs_pkg::DUR_W-1:0]   duration_value;

	modport source (output valid, op, time_delta, table_index, duration_value, input ready);
	modport sink   (input valid, op, time_delta, table_index, duration_value, output ready);
endinterface

interface sfs_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [sfs_pkg::FIDX_W-1:0]  frame_index;
	logic                        is_playing;
	logic [sfs_pkg::ADV_W-1:0]   frames_advanced;
	logic                        finished;

	modport source (output valid, frame_index, is_playing, frames_advanced, finished,
		input ready);
	modport sink   (input valid, frame_index, is_playing, frames_advanced, finished,
		output ready);
endinterface

@@ sv/sfs_alu.sv @@
// Shared 40-bit add/subtract unit for the accumulator.
// Depends on sfs_pkg for the request and answer structs.
`timescale 1ns / 1ps

module sfs_alu (
	input  sfs_pkg::alu_req_t req,
	output sfs_pkg::alu_rsp_t rsp
);
	import sfs_pkg::*;

	logic [ACC_W:0] sum;

	// One extra bit gives carry on add and borrow on subtract
	always_comb begin
		if (req.sub) begin
			sum = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			sum = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.value = sum[ACC_W-1:0];
		rsp.carry = sum[ACC_W];
	end

endmodule

@@ sv/sfs_dur_table.sv @@
// Per-frame duration memory with valid bits and registered read.
// Depends on sfs_pkg for the duration width.
`timescale 1ns / 1ps

module sfs_dur_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [sfs_pkg::DUR_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [sfs_pkg::DUR_W-1:0] rd_data
);
	import sfs_pkg::*;

	logic [DUR_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [DUR_W-1:0] rd_data_q;

	// Entry valid bits: reset makes every entry read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Storage write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; unwritten entries give zero
	always_ff @(posedge clk) begin
		rd_data_q <= vld_q[rd_addr] ? mem[rd_addr] : '0;
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/sprite_frame_sequencer.sv @@
// Top level of the sprite frame sequencer: sequencer, registers, APB port.
// Depends on sfs_pkg, sfs_if, sfs_alu and sfs_dur_table.
//
// Usage:
//  cmd carries one item per valid/ready handshake: tick, start, resume,
//  stop, pause or duration write. rsp returns exactly one status item per
//  command: frame index, playing flag, frames advanced and finished flag.
//  Registers frame_count, loop_enable, default_period and playback_speed
//  are written over the APB port at byte addresses 0, 4, 8 and 12, and the
//  user must write them only while no command is in flight: the block does
//  not enforce it. One item at a time: cmd.ready is low from acceptance
//  until the status item is taken. A non-tick item or an idle tick goes
//  from S_EXEC straight to S_OUT, where rsp.valid is high. A live tick
//  multiplies in S_EXEC, does one saturating add in S_ADD, then takes off
//  one frame duration in S_CHECK per frame advance (at most 64) and ends
//  with a final compare, or leaves S_CHECK on an advance that ends a one-shot
//  clip. The next item can be accepted in the cycle after rsp is taken.
//  A stalled rsp simply holds its item and keeps cmd blocked.
//  Reset clears playback state, the duration table and the registers to
//  their defaults at once; the block is ready in the first cycle after.
`timescale 1ns / 1ps

module sprite_frame_sequencer #(
	parameter int MAX_FRAMES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sfs_cmd_if.sink                     cmd,
	sfs_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfs_pkg::PADDR_W-1:0] paddr,
	input  logic [sfs_pkg::PDATA_W-1:0] pwdata,
	output logic [sfs_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import sfs_pkg::*;

	// Frames a clip can reach are bounded by the table and the 5-bit count
	localparam int CLIP_MAX = (MAX_FRAMES < 31) ? MAX_FRAMES : 31;
	localparam int CFW      = (CLIP_MAX > 1) ? $clog2(CLIP_MAX) : 1;
	localparam int TIW      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam logic [FC_W-1:0] CLIP_MAX_C = FC_W'(CLIP_MAX);
	localparam logic [8:0]      DEPTH_C    = 9'(MAX_FRAMES);

	// Sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_ADD   = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]             state_q, state_d;
	logic [FC_W-1:0]        frame_count_q;
	logic                   loop_q;
	logic [DUR_W-1:0]       default_q;
	logic [SPEED_W-1:0]     speed_q;
	logic [CFW-1:0]         cur_q, cur_d;
	logic [ACC_W-1:0]       acc_q, acc_d;
	logic                   running_q, running_d;
	logic                   loaded_q, loaded_d;
	logic [ADV_W-1:0]       adv_q, adv_d;
	logic                   done_q, done_d;
	logic [OP_W-1:0]        op_q;
	logic [DUR_W-1:0]       delta_q;
	logic [TIDX_W-1:0]      tidx_q;
	logic [DUR_W-1:0]       dval_q;
	logic [2*DUR_W-1:0]     prod_q;

	logic [FC_W-1:0]        eff_count;
	logic [FC_W-1:0]        cur_ext;
	logic                   in_range;
	logic                   next_ok;
	logic                   tick_live;
	logic                   idx_ok;
	logic [DUR_W-1:0]       tbl_rd;
	logic [DUR_W-1:0]       dur;
	logic                   tbl_we;
	logic                   cfg_we;
	logic [1:0]             cfg_idx;
	logic                   accept;
	alu_req_t               alu_req;
	alu_rsp_t               alu_rsp;

	// Handshakes
	assign accept    = cmd.valid & cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign rsp.valid = (state_q == S_OUT);
	assign rsp.frame_index     = FIDX_W'(cur_q);
	assign rsp.is_playing      = running_q;
	assign rsp.frames_advanced = adv_q;
	assign rsp.finished        = done_q;

	// Clip bounds and current duration
	assign eff_count = (frame_count_q > CLIP_MAX_C) ? CLIP_MAX_C : frame_count_q;
	assign cur_ext   = FC_W'(cur_q);
	assign in_range  = cur_ext < eff_count;
	assign next_ok   = (cur_ext + FC_W'(1)) < eff_count;
	assign tick_live = running_q & loaded_q & (eff_count != '0) & (speed_q != '0);
	assign idx_ok    = 9'(tidx_q) < DEPTH_C;
	assign dur       = !in_range ? '0 : ((tbl_rd != '0) ? tbl_rd : default_q);

	// Shared unit: add the scaled delta, or take off one frame duration
	assign alu_req.sub = (state_q == S_CHECK);
	assign alu_req.a   = acc_q;
	assign alu_req.b   = alu_req.sub ? {{(ACC_W-DUR_W-FRAC_W){1'b0}}, dur, {FRAC_W{1'b0}}}
	                                 : {{(ACC_W-2*DUR_W){1'b0}}, prod_q};

	sfs_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Read address follows the next frame so its data is ready in the following cycle
	sfs_dur_table #(
		.DEPTH (MAX_FRAMES),
		.AW    (TIW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (tbl_we),
		.wr_addr (TIW'(tidx_q)),
		.wr_data (dval_q),
		.rd_addr (TIW'(cur_d)),
		.rd_data (tbl_rd)
	);

	// Sequencer next state
	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		acc_d     = acc_q;
		running_d = running_q;
		loaded_d  = loaded_q;
		adv_d     = adv_q;
		done_d    = done_q;
		tbl_we    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					adv_d   = '0;
					done_d  = 1'b0;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
				case (op_q)
					OP_TICK: begin
						if (tick_live) begin
							state_d = S_ADD;
						end
					end
					OP_START: begin
						if (eff_count != '0) begin
							loaded_d  = 1'b1;
							cur_d     = '0;
							acc_d     = '0;
							running_d = 1'b1;
						end
					end
					OP_RESUME: running_d = loaded_q;
					OP_STOP: begin
						cur_d     = '0;
						acc_d     = '0;
						running_d = 1'b0;
					end
					OP_PAUSE: running_d = 1'b0;
					OP_WRDUR: tbl_we = idx_ok;
					default: ;
				endcase
			end
			S_ADD: begin
				// saturate on overflow of the accumulator
				acc_d   = alu_rsp.carry ? '1 : alu_rsp.value;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (adv_q == ADV_CAP || !running_q || dur == '0 || alu_rsp.carry) begin
					state_d = S_OUT;
				end else begin
					acc_d = alu_rsp.value;
					adv_d = adv_q + ADV_W'(1);
					if (next_ok) begin
						cur_d = CFW'(cur_ext + FC_W'(1));
					end else if (loop_q) begin
						cur_d = '0;
					end else begin
						// end of a one-shot clip
						acc_d     = '0;
						running_d = 1'b0;
						done_d    = 1'b1;
						state_d   = S_OUT;
					end
				end
			end
			S_OUT: begin
				if (rsp.ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer and playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_q     <= '0;
			acc_q     <= '0;
			running_q <= 1'b0;
			loaded_q  <= 1'b0;
			adv_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			cur_q     <= cur_d;
			acc_q     <= acc_d;
			running_q <= running_d;
			loaded_q  <= loaded_d;
			adv_q     <= adv_d;
			done_q    <= done_d;
		end
	end

	// Item capture and speed product
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= cmd.op;
			delta_q <= cmd.time_delta;
			tidx_q  <= cmd.table_index;
			dval_q  <= cmd.duration_value;
		end
		if (state_q == S_EXEC) begin
			prod_q <= delta_q * speed_q;
		end
	end

	// Configuration registers
	assign pready  = 1'b1;
	assign cfg_idx = paddr[PADDR_W-1:2];
	assign cfg_we  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
			loop_q        <= 1'b0;
			default_q     <= '0;
			speed_q       <= SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_FRAME_COUNT:    frame_count_q <= pwdata[FC_W-1:0];
				REG_LOOP_ENABLE:    loop_q        <= pwdata[0];
				REG_DEFAULT_PERIOD: default_q     <= pwdata[DUR_W-1:0];
				REG_PLAYBACK_SPEED: speed_q       <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back
	always_comb begin
		unique case (cfg_idx)
			REG_FRAME_COUNT:    prdata = PDATA_W'(frame_count_q);
			REG_LOOP_ENABLE:    prdata = PDATA_W'(loop_q);
			REG_DEFAULT_PERIOD: prdata = PDATA_W'(default_q);
			REG_PLAYBACK_SPEED: prdata = PDATA_W'(speed_q);
			default:            prdata = '0;
		endcase
	end

endmodule

@@ sv/sfs_checker.sv @@
// Port-level checker for the sprite frame sequencer, bound to the top level.
// Depends on sfs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfs_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cmd_valid,
	input logic                       cmd_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [sfs_pkg::FIDX_W-1:0] frame_index,
	input logic                       is_playing,
	input logic [sfs_pkg::ADV_W-1:0]  frames_advanced,
	input logic                       finished
);
	import sfs_pkg::*;

	// A stalled status item holds
	`SFS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(frame_index) && $stable(is_playing) && $stable(frames_advanced) && $stable(finished), "status item changed while stalled")

	// One item in flight: no command taken while a status item waits
	`SFS_ASSERT_IMP(a_busy, clk, arst_n, rsp_valid, !cmd_ready, "command ready while status pending")

	// An accepted command blocks the channel and has no status yet
	`SFS_ASSERT_NXT(a_accept_blocks, clk, arst_n, cmd_valid && cmd_ready, !cmd_ready && !rsp_valid, "channel not blocked after accept")

	// Advance count never exceeds the per-tick cap
	`SFS_ASSERT_IMP(a_adv_cap, clk, arst_n, rsp_valid, frames_advanced <= ADV_CAP, "too many frames advanced")

	// A finished clip has stopped and consumed at least one frame
	`SFS_ASSERT_IMP(a_finish, clk, arst_n, rsp_valid && finished, !is_playing && frames_advanced != '0, "finished status inconsistent")

endmodule

bind sprite_frame_sequencer sfs_checker u_sfs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.frame_index     (rsp.frame_index),
	.is_playing      (rsp.is_playing),
	.frames_advanced (rsp.frames_advanced),
	.finished        (rsp.finished)
);

@@ tb/sfs_status_monitor.sv @@
// Status checker for the sprite frame sequencer: watches the command, status and register ports,
// predicts every status item and compares it field by field. Depends on sfs_pkg and sfs_if.
`timescale 1ns / 1ps

module sfs_status_monitor (
	input  logic                        clk,
	input  logic                        arst_n,
	sfs_cmd_if                          cmd,
	sfs_rsp_if                          rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [sfs_pkg::PADDR_W-1:0] paddr,
	input  logic [sfs_pkg::PDATA_W-1:0] pwdata,
	output int                          fail_count,
	output int                          due_count,
	output int                          checked_count,
	output int                          advance_total
);
	import sfs_pkg::*;

	localparam int MAX_FRAMES = 16;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DUR_W-1:0]  time_delta;
		logic [TIDX_W-1:0] table_index;
		logic [DUR_W-1:0]  duration_value;
	} cmd_item_t;

	typedef struct packed {
		logic [FIDX_W-1:0] frame_index;
		logic              is_playing;
		logic [ADV_W-1:0]  frames_advanced;
		logic              finished;
	} status_t;

	// Shadow of the playback state and the registers
	logic [FIDX_W-1:0]  cur_frame;
	logic [ACC_W-1:0]   accum;
	logic               playing;
	logic               loaded;
	logic [DUR_W-1:0]   dur_tab [MAX_FRAMES];
	logic [FC_W-1:0]    cfg_count;
	logic               cfg_loop;
	logic [DUR_W-1:0]   cfg_period;
	logic [SPEED_W-1:0] cfg_speed;

	status_t status_due [$];
	int      mismatches;
	int      checked;
	int      advances;

	assign fail_count    = mismatches;
	assign checked_count = checked;
	assign advance_total = advances;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch in %s of status item %0d: got %0d, expected %0d",
			what, checked, got, want);
		mismatches++;
	endtask

	// Frame count clamped to the table size
	function automatic logic [FC_W-1:0] clip_len();
		return (cfg_count > FC_W'(MAX_FRAMES)) ? FC_W'(MAX_FRAMES) : cfg_count;
	endfunction

	// Duration of the current frame; zero stalls playback
	function automatic logic [DUR_W-1:0] cur_duration();
		if (!loaded || FC_W'(cur_frame) >= clip_len())
			return '0;
		if (dur_tab[cur_frame] != '0)
			return dur_tab[cur_frame];
		return cfg_period;
	endfunction

	// Apply one command to the shadow state and give the status it should produce
	function automatic status_t play_step(input cmd_item_t c);
		logic [ACC_W:0]   sum;
		logic [ACC_W-1:0] need;
		logic [ADV_W-1:0] adv;
		logic             done;
		status_t          s;
		adv  = '0;
		done = 1'b0;
		case (c.op)
			OP_TICK: begin
				if (playing && loaded && clip_len() != '0 && cfg_speed != '0) begin
					sum = {1'b0, accum} + (41'(c.time_delta) * 41'(cfg_speed));
					accum = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
					for (int n = 0; n < MAX_ADVANCE && playing; n++) begin
						need = {16'd0, cur_duration(), 8'd0};
						if (need == '0 || accum < need)
							break;
						accum = accum - need;
						adv++;
						if (FC_W'(cur_frame) + FC_W'(1) < clip_len()) begin
							cur_frame++;
						end else if (cfg_loop) begin
							cur_frame = '0;
						end else begin
							accum   = '0;
							playing = 1'b0;
							done    = 1'b1;
						end
					end
				end
			end
			OP_START: begin
				if (clip_len() != '0) begin
					loaded    = 1'b1;
					cur_frame = '0;
					accum     = '0;
					playing   = 1'b1;
				end
			end
			OP_RESUME: playing = loaded;
			OP_STOP: begin
				cur_frame = '0;
				accum     = '0;
				playing   = 1'b0;
			end
			OP_PAUSE: playing = 1'b0;
			OP_WRDUR: dur_tab[c.table_index] = c.duration_value;
			default: ;
		endcase
		s.frame_index     = cur_frame;
		s.is_playing      = playing;
		s.frames_advanced = adv;
		s.finished        = done;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cmd_item_t item;
		status_t   want;
		if (!arst_n) begin
			cur_frame  = '0;
			accum      = '0;
			playing    = 1'b0;
			loaded     = 1'b0;
			for (int i = 0; i < MAX_FRAMES; i++)
				dur_tab[i] = '0;
			cfg_count  = FRAME_COUNT_RST;
			cfg_loop   = 1'b0;
			cfg_period = '0;
			cfg_speed  = SPEED_RST;
			status_due.delete();
			mismatches = 0;
			checked    = 0;
			advances   = 0;
			due_count  = 0;
		end else begin
			// status item taken: compare with the oldest prediction
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (status_due.size() == 0) begin
					report("presence (none expected)", 1, 0);
				end else begin
					want = status_due.pop_front();
					if (rsp.frame_index !== want.frame_index)
						report("frame_index", rsp.frame_index, want.frame_index);
					if (rsp.is_playing !== want.is_playing)
						report("is_playing", rsp.is_playing, want.is_playing);
					if (rsp.frames_advanced !== want.frames_advanced)
						report("frames_advanced", rsp.frames_advanced, want.frames_advanced);
					if (rsp.finished !== want.finished)
						report("finished", rsp.finished, want.finished);
					advances += want.frames_advanced;
				end
				checked++;
			end
			// command item taken: predict its status
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1) begin
				item.op             = cmd.op;
				item.time_delta     = cmd.time_delta;
				item.table_index    = cmd.table_index;
				item.duration_value = cmd.duration_value;
				status_due.push_back(play_step(item));
			end
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FRAME_COUNT:    cfg_count  = pwdata[FC_W-1:0];
					REG_LOOP_ENABLE:    cfg_loop   = pwdata[0];
					REG_DEFAULT_PERIOD: cfg_period = pwdata[DUR_W-1:0];
					REG_PLAYBACK_SPEED: cfg_speed  = pwdata[SPEED_W-1:0];
					default: ;
				endcase
			end
			due_count = status_due.size();
		end
	end

endmodule

@@ tb/tb_sprite_frame_sequencer.sv @@
// Testbench top for the sprite frame sequencer: clock, reset, command and register stimulus,
// random handshake gaps and the verdict. Depends on sfs_pkg, sfs_if and sfs_status_monitor.
`timescale 1ns / 1ps

module tb_sprite_frame_sequencer;
	import sfs_pkg::*;

	// Opcodes the block leaves unused
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int due_count;
	int checked_count;
	int advance_total;
	int items_sent;
	int settings_used;
	bit calm;

	sfs_cmd_if cmd ();
	sfs_rsp_if rsp ();

	sprite_frame_sequencer uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	sfs_status_monitor status_mon (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rsp           (rsp),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.due_count     (due_count),
		.checked_count (checked_count),
		.advance_total (advance_total)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#10_000_000;
		$display("timeout: handshakes stopped completing");
		$display("simulation failed");
		$finish;
	end

	function automatic int wait_len();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// Status side: random stall before taking each item
	initial begin
		int stall;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = wait_len();
			if (stall > 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp.ready <= 1'b1;
			do @(posedge clk); while (rsp.valid !== 1'b1);
		end
	end

	// One command item, after a random gap; returns at the accepting edge
	task automatic send(input logic [OP_W-1:0] op, input logic [DUR_W-1:0] delta,
		input logic [TIDX_W-1:0] idx, input logic [DUR_W-1:0] dval);
		int gap;
		gap = wait_len();
		if (gap > 0) begin
			@(negedge clk);
			cmd.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd.valid          <= 1'b1;
		cmd.op             <= op;
		cmd.time_delta     <= delta;
		cmd.table_index    <= idx;
		cmd.duration_value <= dval;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		items_sent++;
	endtask

	// Drop valid and wait until every predicted status item has come back
	task automatic wait_idle();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (due_count != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// New register setting, written only once the block is idle
	task automatic configure(input logic [FC_W-1:0] fc, input logic lp,
		input logic [DUR_W-1:0] defp, input logic [SPEED_W-1:0] spd);
		wait_idle();
		reg_write(REG_FRAME_COUNT, PDATA_W'(fc));
		reg_write(REG_LOOP_ENABLE, PDATA_W'(lp));
		reg_write(REG_DEFAULT_PERIOD, PDATA_W'(defp));
		reg_write(REG_PLAYBACK_SPEED, PDATA_W'(spd));
		settings_used++;
	endtask

	initial begin
		int                 r;
		int                 s;
		logic [OP_W-1:0]    op;
		logic [DUR_W-1:0]   delta;
		logic [DUR_W-1:0]   dval;
		logic [TIDX_W-1:0]  idx;
		logic [FC_W-1:0]    fc;
		logic               lp;
		logic [DUR_W-1:0]   defp;
		logic [SPEED_W-1:0] spd;

		arst_n             = 1'b0;
		cmd.valid          = 1'b0;
		cmd.op             = OP_TICK;
		cmd.time_delta     = '0;
		cmd.table_index    = '0;
		cmd.duration_value = '0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		items_sent         = 0;
		settings_used      = 0;
		calm               = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: resume with no clip, idle tick, unused ops, table writes
		send(OP_RESUME, 16'd0, 4'd0, 16'd0);
		send(OP_TICK, 16'hFFFF, 4'd0, 16'd0);
		send(OP_SPARE_LO, 16'd0, 4'd0, 16'd0);
		send(OP_SPARE_HI, 16'hFFFF, 4'hF, 16'hFFFF);
		send(OP_WRDUR, 16'd0, 4'd0, 16'd0);
		send(OP_WRDUR, 16'd0, 4'hF, 16'hFFFF);
		send(OP_WRDUR, 16'd0, 4'd5, 16'd3);
		// zero period: time piles up without advancing
		send(OP_START, 16'd0, 4'd0, 16'd0);
		send(OP_TICK, 16'd100, 4'd0, 16'd0);
		// full speed, big delta: advance cap with leftover time
		configure(5'd16, 1'b1, 16'd2, 16'hFFFF);
		send(OP_TICK, 16'hFFFF, 4'd0, 16'd0);
		send(OP_STOP, 16'd0, 4'd0, 16'd0);
		send(OP_START, 16'd0, 4'd0, 16'd0);
		send(OP_PAUSE, 16'd0, 4'd0, 16'd0);
		send(OP_RESUME, 16'd0, 4'd0, 16'd0);
		send(OP_TICK, 16'd300, 4'd0, 16'd0);
		// empty clip: start ignored
		send(OP_STOP, 16'd0, 4'd0, 16'd0);
		configure(5'd0, 1'b1, 16'd2, 16'd256);
		send(OP_START, 16'd0, 4'd0, 16'd0);
		send(OP_TICK, 16'd500, 4'd0, 16'd0);
		// oversized clip, zero speed, then run to the end without looping
		configure(5'd31, 1'b0, 16'd1, 16'd0);
		send(OP_START, 16'd0, 4'd0, 16'd0);
		send(OP_TICK, 16'hFFFF, 4'd0, 16'd0);
		send(OP_WRDUR, 16'd0, 4'hF, 16'd0);
		configure(5'd31, 1'b0, 16'd1, 16'd256);
		send(OP_TICK, 16'hFFFF, 4'd0, 16'd0);
		// frame left beyond a shortened clip
		configure(5'd16, 1'b1, 16'd1, 16'd256);
		send(OP_START, 16'd0, 4'd0, 16'd0);
		send(OP_TICK, 16'd10, 4'd0, 16'd0);
		configure(5'd2, 1'b1, 16'd1, 16'd256);
		send(OP_TICK, 16'd10, 4'd0, 16'd0);

		// Random phases, each under a fresh register setting
		for (int p = 0; p < 9; p++) begin
			if (p == 4) begin
				// saturate the accumulator while stalled, then drain at the cap
				configure(5'd16, 1'b1, 16'd0, 16'hFFFF);
				send(OP_WRDUR, 16'($urandom_range(0, 65535)), 4'd0, 16'd0);
				send(OP_START, 16'd0, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
				for (int n = 0; n < 260; n++) begin
					if (n % 20 == 0)
						calm = ($urandom_range(0, 3) == 0);
					send(OP_TICK, 16'hFFFF, 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)));
				end
				configure(5'd16, 1'b1, 16'd1, 16'hFFFF);
				repeat (4) send(OP_TICK, 16'd0, 4'd0, 16'd0);
			end

			case ($urandom_range(0, 9))
				0:       fc = 5'd1;
				1:       fc = 5'd16;
				2:       fc = 5'd0;
				3:       fc = 5'($urandom_range(17, 31));
				default: fc = 5'($urandom_range(1, 16));
			endcase
			lp = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 7))
				0:       defp = 16'd0;
				1:       defp = 16'hFFFF;
				2:       defp = 16'($urandom_range(0, 65535));
				default: defp = 16'($urandom_range(1, 24));
			endcase
			case ($urandom_range(0, 9))
				0:       spd = 16'd0;
				1:       spd = 16'hFFFF;
				2:       spd = 16'($urandom_range(0, 65535));
				3:       spd = 16'($urandom_range(1, 64));
				4, 5:    spd = 16'($urandom_range(128, 512));
				default: spd = 16'd256;
			endcase
			configure(fc, lp, defp, spd);

			for (int n = 0; n < 85; n++) begin
				if (n % 20 == 0)
					calm = ($urandom_range(0, 3) == 0);
				r     = $urandom_range(0, 99);
				idx   = 4'($urandom_range(0, 15));
				dval  = 16'($urandom_range(0, 65535));
				delta = 16'($urandom_range(0, 65535));
				if (r < 55) begin
					op = OP_TICK;
					s  = $urandom_range(0, 19);
					if (s == 0)
						delta = 16'd0;
					else if (s == 1)
						delta = 16'hFFFF;
					else if (s > 3)
						delta = 16'($urandom_range(1, 64));
				end else if (r < 67) begin
					op = OP_WRDUR;
					s  = $urandom_range(0, 9);
					if (s < 3)
						dval = 16'd0;
					else if (s == 3)
						dval = 16'hFFFF;
					else if (s > 4)
						dval = 16'($urandom_range(1, 32));
				end else if (r < 77) begin
					op = OP_START;
				end else if (r < 84) begin
					op = OP_RESUME;
				end else if (r < 89) begin
					op = OP_STOP;
				end else if (r < 95) begin
					op = OP_PAUSE;
				end else begin
					op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
				end
				send(op, delta, idx, dval);
			end
		end

		// Drain and let the block settle
		calm = 1'b0;
		wait_idle();
		repeat (80) @(posedge clk);

		$display("covered %0d command items under %0d register settings,", items_sent,
			settings_used);
		$display("%0d status items checked, %0d frame advances predicted", checked_count,
			advance_total);
		if (fail_count == 0 && due_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
